### design/asof_pkg.sv
package asof_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OBJECT_HGT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_HGT   = 2'd3;

    // Register reset values
    localparam logic [11:0] TOLERANCE_RST  = 12'd300;
    localparam logic [11:0] OBJECT_HGT_RST = 12'd2000;
    localparam logic [15:0] TIMEOUT_RST    = 16'd250;
    localparam logic [11:0] START_HGT_RST  = 12'd300;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    // Item commands
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic MODE_GROUND = 1'b0;
    localparam logic MODE_OBJECT = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] sample_mm;
    } t_in_item;

    typedef struct packed {
        logic [15:0] estimate_mm;
        logic        over_object;
        logic        rejecting;
    } t_out_item;

endpackage

### design/altitude_step_outlier_filter_unit.sv
// Altitude step/outlier filter.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries either a tick
// (cmd 0) or a height sample in mm (cmd 1). Each transfer in yields exactly one
// result transfer on the output channel (o_out_valid / i_out_stall /
// o_out_data) with the estimate, the mode and the rejecting flag after it.
// The input transfer is captured in the input register, then the filter step
// writes the result register. Throughput: one item per cycle while the
// receiver does not stall; the state update is a combinational
// compare/select loop on the registered estimate.
// When the receiver stalls, the result register holds, the input register
// fills behind it and o_in_stall rises only when both are occupied and the
// result is stalled.
// Configuration (i_cfg_we / i_cfg_index / i_cfg_data): the user writes it only
// while idle (unenforced); writing the start height also reloads the estimate.
// Synchronous active-low reset clears both stages, loads the register
// defaults, sets the estimate to the start height, ground mode, no rejecting.
module altitude_step_outlier_filter_unit #(
    parameter int unsigned ALT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  asof_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output asof_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [asof_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [asof_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import asof_pkg::*;

    // compare width: covers the estimate and a lifted 17-bit sample
    localparam int unsigned CW = (ALT_BITS > 17) ? ALT_BITS : 17;
    localparam logic [CW-1:0] ALT_MAX = CW'((64'd1 << ALT_BITS) - 64'd1);
    localparam logic [CW-1:0] OUT_MAX = CW'(17'h0FFFF);

    logic [11:0]         r_tol;
    logic [11:0]         r_obj;
    logic [15:0]         r_timeout;

    logic [ALT_BITS-1:0] r_est, n_est;
    logic                r_mode, n_mode;
    logic                r_check, n_check;
    logic [15:0]         r_ticks, n_ticks;

    logic                r_in_valid;
    t_in_item            r_in;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                fire;
    logic                in_take;

    logic [CW-1:0]       est_x, raw_x, lift_x, d_raw, d_lift, tol_x;
    logic                fit_raw, fit_obj;

    function automatic logic [CW-1:0] sat_alt(input logic [CW-1:0] v);
        return (v > ALT_MAX) ? ALT_MAX : v;
    endfunction

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    assign est_x  = CW'(r_est);
    assign raw_x  = CW'(r_in.sample_mm);
    assign lift_x = CW'(r_in.sample_mm) + CW'(r_obj);
    assign tol_x  = CW'(r_tol);
    assign d_raw  = (est_x > raw_x) ? est_x - raw_x : raw_x - est_x;
    assign d_lift = (est_x > lift_x) ? est_x - lift_x : lift_x - est_x;
    assign fit_raw = d_raw < tol_x;
    assign fit_obj = d_lift < tol_x;

    always_comb begin
        n_est   = r_est;
        n_mode  = r_mode;
        n_check = r_check;
        n_ticks = r_ticks;
        if (r_in.cmd == CMD_TICK) begin
            if (r_ticks != TICK_MAX) begin
                n_ticks = r_ticks + 16'd1;
            end
        end else if (r_mode == MODE_GROUND && fit_raw) begin
            n_est   = ALT_BITS'(sat_alt(raw_x));
            n_mode  = MODE_GROUND;
            n_check = 1'b0;
        end else if (fit_obj) begin
            n_est   = ALT_BITS'(sat_alt(lift_x));
            n_mode  = MODE_OBJECT;
            n_check = 1'b0;
        end else if (fit_raw) begin
            n_est   = ALT_BITS'(sat_alt(raw_x));
            n_mode  = MODE_GROUND;
            n_check = 1'b0;
        end else if (!r_check) begin
            // first bad sample starts the timer
            n_ticks = 16'd0;
            n_check = 1'b1;
        end else if (r_ticks > r_timeout) begin
            n_est   = ALT_BITS'(sat_alt(raw_x));
            n_mode  = MODE_GROUND;
            n_check = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOLERANCE_RST;
            r_obj       <= OBJECT_HGT_RST;
            r_timeout   <= TIMEOUT_RST;
            r_est       <= ALT_BITS'(START_HGT_RST);
            r_mode      <= MODE_GROUND;
            r_check     <= 1'b0;
            r_ticks     <= 16'd0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_est   <= n_est;
                r_mode  <= n_mode;
                r_check <= n_check;
                r_ticks <= n_ticks;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TOLERANCE:  r_tol     <= i_cfg_data[11:0];
                    REG_OBJECT_HGT: r_obj     <= i_cfg_data[11:0];
                    REG_TIMEOUT:    r_timeout <= i_cfg_data[15:0];
                    REG_START_HGT: begin
                        r_est <= ALT_BITS'(i_cfg_data[11:0]);
                    end
                    default: ;
                endcase
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out.estimate_mm <= (CW'(n_est) > OUT_MAX) ? 16'hFFFF : 16'(CW'(n_est));
            r_out.over_object <= n_mode;
            r_out.rejecting   <= n_check;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled while a stage is free");

    a_tick_keeps_estimate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.cmd == CMD_TICK && !i_cfg_we)
            |=> (r_est == $past(r_est) && r_mode == $past(r_mode)
                 && r_check == $past(r_check)))
        else $error("tick moved the estimate or mode");

    a_result_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out_valid && r_out.over_object == r_mode
                  && r_out.rejecting == r_check))
        else $error("result does not match the state after the step");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !r_in_valid) |=> !r_out_valid)
        else $error("result repeated after its transfer");

endmodule
